### sv/snict_pkg.sv
// ----------------------------------------------------------------------------
// snict_pkg
// Shared types and constants of the non-INVITE client transaction block.
// ----------------------------------------------------------------------------
`default_nettype none

package snict_pkg;

  // Field widths.
  localparam int CMD_WIDTH       = 3;
  localparam int CODE_WIDTH      = 10;
  localparam int OUTCOME_WIDTH   = 2;
  localparam int PHASE_WIDTH     = 2;
  localparam int STATUS_WIDTH    = 2;
  localparam int CFG_WIDTH       = 16;
  localparam int CFG_INDEX_WIDTH = 2;

  localparam int TIMER_WIDTH_DEFAULT = 16;

  // Transaction phases.
  typedef enum logic [PHASE_WIDTH-1:0] {
    PH_IDLE       = 2'd0,
    PH_TRYING     = 2'd1,
    PH_PROCEEDING = 2'd2,
    PH_COMPLETED  = 2'd3
  } phase_t;

  // Event commands.
  localparam logic [CMD_WIDTH-1:0] CMD_START      = 3'd0;
  localparam logic [CMD_WIDTH-1:0] CMD_PEER_MSG   = 3'd1;
  localparam logic [CMD_WIDTH-1:0] CMD_TICK       = 3'd2;
  localparam logic [CMD_WIDTH-1:0] CMD_TCP_READY  = 3'd3;
  localparam logic [CMD_WIDTH-1:0] CMD_TRANS_FAIL = 3'd4;

  // Send outcomes; the unused code behaves as UDP.
  localparam logic [OUTCOME_WIDTH-1:0] SEND_UDP    = 2'd0;
  localparam logic [OUTCOME_WIDTH-1:0] SEND_TCP    = 2'd1;
  localparam logic [OUTCOME_WIDTH-1:0] SEND_FAILED = 2'd2;

  // Status codes.
  localparam logic [STATUS_WIDTH-1:0] ST_OK      = 2'd0;
  localparam logic [STATUS_WIDTH-1:0] ST_INVALID = 2'd1;
  localparam logic [STATUS_WIDTH-1:0] ST_NETWORK = 2'd2;

  // Configuration register indexes.
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_T1      = 2'd0;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_T2      = 2'd1;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_TIMEOUT = 2'd2;
  localparam logic [CFG_INDEX_WIDTH-1:0] REG_LINGER  = 2'd3;

  // Configuration reset values.
  localparam logic [CFG_WIDTH-1:0] T1_RESET      = 16'd500;
  localparam logic [CFG_WIDTH-1:0] T2_RESET      = 16'd4000;
  localparam logic [CFG_WIDTH-1:0] TIMEOUT_RESET = 16'd32000;
  localparam logic [CFG_WIDTH-1:0] LINGER_RESET  = 16'd5000;

  // Provisional responses are codes 100 through 199.
  localparam logic [CODE_WIDTH-1:0] CODE_PROV_MIN  = 10'd100;
  localparam logic [CODE_WIDTH-1:0] CODE_FINAL_MIN = 10'd200;

endpackage

`default_nettype wire

### sv/sip_non_invite_client_transaction.sv
// ----------------------------------------------------------------------------
// sip_non_invite_client_transaction
// Client side of a non-INVITE request exchange with timers E, F and K.
// ----------------------------------------------------------------------------
// The block takes one event per clock cycle and returns exactly one result
// for each, in the cycle after the event is accepted. The event is decoded
// against the phase and timer registers in combinational logic, and the
// result lands in an output register; in_stall is raised only during reset and
// while that register holds a result that the downstream side is stalling, so
// events flow at one per cycle whenever the output side keeps up. Timers count
// tick events, not clock cycles. Configuration writes are always ready.
`default_nettype none

module sip_non_invite_client_transaction #(
  parameter int TIMER_WIDTH = snict_pkg::TIMER_WIDTH_DEFAULT
) (
  input  wire logic                                  clk,
  input  wire logic                                  rst,
  // Event channel.
  input  wire logic                                  in_valid,
  output logic                                       in_stall,
  input  wire logic [snict_pkg::CMD_WIDTH-1:0]       command,
  input  wire logic [snict_pkg::CODE_WIDTH-1:0]      response_code,
  input  wire logic                                  msg_is_request,
  input  wire logic [snict_pkg::OUTCOME_WIDTH-1:0]   send_outcome,
  // Result channel.
  output logic                                       out_valid,
  input  wire logic                                  out_stall,
  output logic [snict_pkg::PHASE_WIDTH-1:0]          phase,
  output logic                                       send_request,
  output logic                                       forward_response,
  output logic                                       report_error,
  output logic                                       finished,
  output logic [snict_pkg::STATUS_WIDTH-1:0]         status,
  // Configuration write channel.
  input  wire logic                                  cfg_valid,
  output logic                                       cfg_ready,
  input  wire logic [snict_pkg::CFG_INDEX_WIDTH-1:0] cfg_index,
  input  wire logic [snict_pkg::CFG_WIDTH-1:0]       cfg_data
);

  import snict_pkg::*;

  localparam int TW    = TIMER_WIDTH;
  localparam int CMP_W = (TW + 1 > CFG_WIDTH) ? TW + 1 : CFG_WIDTH;

  typedef logic [TW-1:0] timer_t;

  // Configuration registers.
  logic [CFG_WIDTH-1:0] t1_ticks;
  logic [CFG_WIDTH-1:0] t2_ticks;
  logic [CFG_WIDTH-1:0] timeout_ticks;
  logic [CFG_WIDTH-1:0] linger_ticks;

  // Transaction state.
  phase_t phase_reg;
  logic   over_tcp;
  timer_t retx_interval;
  timer_t retx_left;
  logic   retx_on;
  timer_t timeout_left;
  logic   timeout_on;
  timer_t linger_left;
  logic   linger_on;

  phase_t phase_next;
  logic   over_tcp_next;
  timer_t retx_interval_next;
  timer_t retx_left_next;
  logic   retx_on_next;
  timer_t timeout_left_next;
  logic   timeout_on_next;
  timer_t linger_left_next;
  logic   linger_on_next;

  logic                    sent;
  logic                    fwd;
  logic                    err;
  logic                    fin;
  logic [STATUS_WIDTH-1:0] stat;
  logic                    term;

  logic                    accept;
  logic                    active;
  logic                    f_fire;
  logic                    e_fire;
  logic                    k_fire;
  logic                    provisional;
  logic [CMP_W-1:0]        dbl_ext;
  logic [CMP_W-1:0]        t2_ext;
  timer_t                  retx_grow;

  assign in_stall  = rst | (out_valid & out_stall);
  assign accept    = in_valid & ~in_stall;
  assign cfg_ready = 1'b1;

  assign active      = (phase_reg == PH_TRYING) || (phase_reg == PH_PROCEEDING);
  assign f_fire      = timeout_on && (timeout_left <= TW'(1));
  assign e_fire      = retx_on && (retx_left <= TW'(1));
  assign k_fire      = linger_on && (linger_left <= TW'(1));
  assign provisional = (response_code >= CODE_PROV_MIN) && (response_code < CODE_FINAL_MIN);

  // Next retransmit interval: doubled in trying, capped at T2; T2 in proceeding.
  assign dbl_ext   = CMP_W'({retx_interval, 1'b0});
  assign t2_ext    = CMP_W'(t2_ticks);
  assign retx_grow = (phase_reg == PH_TRYING && dbl_ext < t2_ext) ? TW'(dbl_ext)
                                                                  : TW'(t2_ticks);

  always_comb begin
    phase_next         = phase_reg;
    over_tcp_next      = over_tcp;
    retx_interval_next = retx_interval;
    retx_left_next     = retx_left;
    retx_on_next       = retx_on;
    timeout_left_next  = timeout_left;
    timeout_on_next    = timeout_on;
    linger_left_next   = linger_left;
    linger_on_next     = linger_on;
    sent = 1'b0;
    fwd  = 1'b0;
    err  = 1'b0;
    fin  = 1'b0;
    stat = ST_OK;
    term = 1'b0;

    if (phase_reg == PH_IDLE) begin
      if (command != CMD_START || !msg_is_request) begin
        stat = ST_INVALID;
      end else begin
        sent = 1'b1;
        if (send_outcome == SEND_FAILED) begin
          term = 1'b1;
          err  = 1'b1;
          fin  = 1'b1;
        end else begin
          phase_next        = PH_TRYING;
          timeout_left_next = TW'(timeout_ticks);
          timeout_on_next   = 1'b1;
          if (send_outcome == SEND_TCP) begin
            over_tcp_next  = 1'b1;
            retx_on_next   = 1'b0;
            retx_left_next = '0;
          end else begin
            over_tcp_next      = 1'b0;
            retx_interval_next = TW'(t1_ticks);
            retx_left_next     = TW'(t1_ticks);
            retx_on_next       = 1'b1;
          end
        end
      end
    end else if (active) begin
      case (command)
        CMD_PEER_MSG: begin
          if (!msg_is_request) begin
            fwd = 1'b1;
            if (provisional) begin
              phase_next = PH_PROCEEDING;
            end else begin
              retx_on_next      = 1'b0;
              retx_left_next    = '0;
              timeout_on_next   = 1'b0;
              timeout_left_next = '0;
              if (over_tcp) begin
                term = 1'b1;
                fin  = 1'b1;
              end else begin
                phase_next       = PH_COMPLETED;
                linger_left_next = TW'(linger_ticks);
                linger_on_next   = 1'b1;
              end
            end
          end
        end
        CMD_TICK: begin
          if (timeout_on) begin
            timeout_left_next = f_fire ? '0 : timeout_left - TW'(1);
          end
          if (retx_on) begin
            retx_left_next = e_fire ? '0 : retx_left - TW'(1);
          end
          // Timeout F takes priority over a retransmit on the same tick.
          if (f_fire) begin
            term = 1'b1;
            err  = 1'b1;
            fin  = 1'b1;
          end else if (e_fire) begin
            retx_on_next = 1'b0;
            sent         = 1'b1;
            if (send_outcome == SEND_FAILED) begin
              term = 1'b1;
              err  = 1'b1;
              fin  = 1'b1;
              stat = ST_INVALID;
            end else if (send_outcome == SEND_TCP) begin
              over_tcp_next = 1'b1;
            end else begin
              over_tcp_next      = 1'b0;
              retx_interval_next = retx_grow;
              retx_left_next     = retx_grow;
              retx_on_next       = 1'b1;
            end
          end
        end
        CMD_TCP_READY: begin
          over_tcp_next = 1'b1;
          sent          = 1'b1;
          if (send_outcome == SEND_FAILED) begin
            stat = (phase_reg == PH_TRYING) ? ST_NETWORK : ST_INVALID;
            term = 1'b1;
            err  = 1'b1;
            fin  = 1'b1;
          end
        end
        CMD_TRANS_FAIL: begin
          term = 1'b1;
          err  = 1'b1;
          fin  = 1'b1;
          stat = ST_NETWORK;
        end
        default: begin
        end
      endcase
    end else begin
      // Completed: only ticks matter, counting down the linger timer.
      if (command == CMD_TICK && linger_on) begin
        linger_left_next = k_fire ? '0 : linger_left - TW'(1);
        if (k_fire) begin
          term = 1'b1;
          fin  = 1'b1;
        end
      end
    end

    if (term) begin
      phase_next         = PH_IDLE;
      over_tcp_next      = 1'b0;
      retx_interval_next = '0;
      retx_left_next     = '0;
      retx_on_next       = 1'b0;
      timeout_left_next  = '0;
      timeout_on_next    = 1'b0;
      linger_left_next   = '0;
      linger_on_next     = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      t1_ticks      <= T1_RESET;
      t2_ticks      <= T2_RESET;
      timeout_ticks <= TIMEOUT_RESET;
      linger_ticks  <= LINGER_RESET;
      phase_reg     <= PH_IDLE;
      over_tcp      <= 1'b0;
      retx_interval <= '0;
      retx_left     <= '0;
      retx_on       <= 1'b0;
      timeout_left  <= '0;
      timeout_on    <= 1'b0;
      linger_left   <= '0;
      linger_on     <= 1'b0;
      out_valid     <= 1'b0;
    end else begin
      if (cfg_valid && cfg_ready) begin
        case (cfg_index)
          REG_T1:      t1_ticks      <= cfg_data;
          REG_T2:      t2_ticks      <= cfg_data;
          REG_TIMEOUT: timeout_ticks <= cfg_data;
          REG_LINGER:  linger_ticks  <= cfg_data;
          default: begin
          end
        endcase
      end
      if (accept) begin
        phase_reg     <= phase_next;
        over_tcp      <= over_tcp_next;
        retx_interval <= retx_interval_next;
        retx_left     <= retx_left_next;
        retx_on       <= retx_on_next;
        timeout_left  <= timeout_left_next;
        timeout_on    <= timeout_on_next;
        linger_left   <= linger_left_next;
        linger_on     <= linger_on_next;
        out_valid     <= 1'b1;
      end else if (!out_stall) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Result payload; loaded only when a request is accepted.
  always_ff @(posedge clk) begin
    if (accept) begin
      phase            <= phase_next;
      send_request     <= sent;
      forward_response <= fwd;
      report_error     <= err;
      finished         <= fin;
      status           <= stat;
    end
  end

endmodule

`default_nettype wire

### sv/snict_checker.sv
// ----------------------------------------------------------------------------
// snict_checker
// Port-level checks of the non-INVITE client transaction block.
// ----------------------------------------------------------------------------
`default_nettype none

module snict_checker (
  input wire logic                                  clk,
  input wire logic                                  rst,
  input wire logic                                  in_valid,
  input wire logic                                  in_stall,
  input wire logic                                  out_valid,
  input wire logic                                  out_stall,
  input wire logic [snict_pkg::PHASE_WIDTH-1:0]     phase,
  input wire logic                                  send_request,
  input wire logic                                  forward_response,
  input wire logic                                  report_error,
  input wire logic                                  finished,
  input wire logic [snict_pkg::STATUS_WIDTH-1:0]    status
);

  import snict_pkg::*;

  // A stalled result keeps its valid and payload.
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(phase) && $stable(status)
      && $stable(finished))
    else $error("stalled result changed");

  // Every accepted request yields a result in the next cycle.
  a_result_follows: assert property (@(posedge clk) disable iff (rst)
    in_valid && !in_stall |=> out_valid)
    else $error("accepted request produced no result");

  // A terminated transaction is always back in idle.
  a_finish_idle: assert property (@(posedge clk) disable iff (rst)
    out_valid && finished |-> phase == PH_IDLE)
    else $error("finished without returning to idle");

  // An error report always ends the transaction.
  a_error_ends: assert property (@(posedge clk) disable iff (rst)
    out_valid && report_error |-> finished)
    else $error("error reported without termination");

  // A forwarded response never comes with a send of the request or an error report.
  a_fwd_no_send: assert property (@(posedge clk) disable iff (rst)
    out_valid && forward_response |-> !send_request && !report_error)
    else $error("forwarded response with send or error");

endmodule

bind sip_non_invite_client_transaction snict_checker u_snict_checker (.*);

`default_nettype wire
